// ----- rtl/qrv_pkg.sv -----
// Shared types and fixed widths for the quaternion point rotation block.
// Used by the front end, the queue, the back end pipeline and the checker.
// No dependencies.
package qrv_pkg;

    // Field width of every input and output coordinate.
    localparam int CompW = 16;
    // Squares and cross products of two components.
    localparam int ProdW = 2 * CompW;
    // Norm n = x^2 + y^2 + z^2 + w^2 is unsigned and at most 2^32.
    localparam int NormW = ProdW + 1;
    // Entries of the scaled rotation matrix n*R, signed.
    localparam int MatW = ProdW + 2;
    // Dot product of a matrix row with the point, signed.
    localparam int AccW = 50;
    // Divider dividend 2*|acc| + n and divisor 2*n.
    localparam int NumW = AccW + 2;
    localparam int DenW = NormW + 1;
    // Rotation keeps the length, so the rounded quotient stays below 2^17.
    localparam int QuoW = CompW + 1;
    localparam int DivSteps = QuoW;
    // Registered stages in the back end: products, matrix, terms, sums,
    // dividend setup, one per quotient bit, and the output register.
    localparam int BackStages = 5 + DivSteps + 1;

    localparam logic signed [CompW-1:0] CompMax = 16'sh7fff;
    localparam logic signed [CompW-1:0] CompMin = 16'sh8000;

    typedef logic signed [CompW-1:0] comp_t;

    // One queued word: the quaternion (a zero one already replaced) and the point.
    typedef struct packed {
        comp_t pz;
        comp_t py;
        comp_t px;
        comp_t qw;
        comp_t qz;
        comp_t qy;
        comp_t qx;
    } item_t;

    localparam int ItemW = $bits(item_t);

    // Handshake between the front end and the queue.
    typedef struct packed {
        logic push;
        logic full;
    } qctl_t;

endpackage

// ----- rtl/qrv_front.sv -----
// Front end: takes input words, replaces a zero quaternion by (1,0,0,0)
// and pushes the classified word into the queue. Depends on qrv_pkg.
module qrv_front
    import qrv_pkg::*;
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ItemW-1:0]   s_tdata,
    input  logic               q_full,
    output qctl_t              qctl,
    output item_t              item
);

    item_t raw;
    logic  zero_quat;

    assign raw = item_t'(s_tdata);

    // A quaternion of zero length falls back to a half turn about x.
    assign zero_quat = (raw.qx == '0) && (raw.qy == '0) && (raw.qz == '0) && (raw.qw == '0);

    always_comb
    begin
        item = raw;
        if (zero_quat)
        begin
            item.qx = comp_t'(1);
        end
    end

    // Accept whenever the queue has room.
    assign s_tready  = !q_full;
    assign qctl.push = s_tvalid && !q_full;
    assign qctl.full = q_full;

endmodule

// ----- rtl/qrv_queue.sv -----
// Short queue between the front end and the back end pipeline.
// Depends on qrv_pkg.
module qrv_queue
    import qrv_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  qctl_t  qctl,
    input  item_t  wr_item,
    output logic   full,
    output logic   empty,
    input  logic   pop,
    output item_t  rd_item
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CntW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = qctl.push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/qrv_back.sv -----
// Back end: builds the scaled rotation matrix, multiplies the point by it
// and divides by the norm with one quotient bit per stage, then saturates.
// Depends on qrv_pkg.
module qrv_back
    import qrv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  item_t              in_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [3*CompW-1:0] m_tdata,
    output logic               m_tuser
);

    logic                     adv;
    logic [BackStages-1:0]    valid_reg;

    // Stage 1: products of components.
    logic signed [ProdW-1:0]  xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [ProdW-1:0]  xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    comp_t                    p1_reg [3];

    // Stage 2: norm and matrix.
    logic [NormW-1:0]         n2_reg;
    logic signed [MatW-1:0]   m2_reg [9];
    comp_t                    p2_reg [3];

    // Stage 3: matrix times point terms.
    logic [NormW-1:0]         n3_reg;
    logic signed [AccW-1:0]   t3_reg [9];

    // Stage 4: row sums.
    logic [NormW-1:0]         n4_reg;
    logic signed [AccW-1:0]   acc4_reg [3];

    // Divider stages, index 0 is the dividend setup.
    logic [NumW-1:0]          rem_reg [DivSteps+1][3];
    logic [QuoW-1:0]          quo_reg [DivSteps+1][3];
    logic                     neg_reg [DivSteps+1][3];
    logic [DenW-1:0]          den_reg [DivSteps+1];

    // Output register.
    logic [3*CompW-1:0]       data_reg;
    logic                     clip_reg;

    // The whole pipeline moves when the output slot is free or taken.
    assign adv      = !valid_reg[BackStages-1] || m_tready;
    assign in_ready = adv;
    assign m_tvalid = valid_reg[BackStages-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[BackStages-2:0], in_valid};
        end
    end

    // Stage 1: the ten component products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg <= in_item.qx * in_item.qx;
            yy_reg <= in_item.qy * in_item.qy;
            zz_reg <= in_item.qz * in_item.qz;
            ww_reg <= in_item.qw * in_item.qw;
            xy_reg <= in_item.qx * in_item.qy;
            xz_reg <= in_item.qx * in_item.qz;
            yz_reg <= in_item.qy * in_item.qz;
            wx_reg <= in_item.qw * in_item.qx;
            wy_reg <= in_item.qw * in_item.qy;
            wz_reg <= in_item.qw * in_item.qz;
            p1_reg[0] <= in_item.px;
            p1_reg[1] <= in_item.py;
            p1_reg[2] <= in_item.pz;
        end
    end

    // Stage 2: norm and the rotation matrix scaled by the norm.
    logic signed [MatW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
    logic signed [MatW-1:0] n_sum;
    assign exx = xx_reg;
    assign eyy = yy_reg;
    assign ezz = zz_reg;
    assign eww = ww_reg;
    assign exy = xy_reg;
    assign exz = xz_reg;
    assign eyz = yz_reg;
    assign ewx = wx_reg;
    assign ewy = wy_reg;
    assign ewz = wz_reg;
    assign n_sum = exx + eyy + ezz + eww;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n2_reg    <= n_sum[NormW-1:0];
            m2_reg[0] <= eww + exx - eyy - ezz;
            m2_reg[1] <= (exy - ewz) <<< 1;
            m2_reg[2] <= (exz + ewy) <<< 1;
            m2_reg[3] <= (exy + ewz) <<< 1;
            m2_reg[4] <= eww - exx + eyy - ezz;
            m2_reg[5] <= (eyz - ewx) <<< 1;
            m2_reg[6] <= (exz - ewy) <<< 1;
            m2_reg[7] <= (eyz + ewx) <<< 1;
            m2_reg[8] <= eww - exx - eyy + ezz;
            p2_reg    <= p1_reg;
        end
    end

    // Stage 3: nine matrix-by-coordinate products.
    logic signed [AccW-1:0] mx [9];
    logic signed [AccW-1:0] px [3];
    for (genvar i = 0; i < 9; i++)
    begin : g_mext
        assign mx[i] = m2_reg[i];
    end
    for (genvar i = 0; i < 3; i++)
    begin : g_pext
        assign px[i] = p2_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n3_reg <= n2_reg;
            for (int i = 0; i < 9; i++)
            begin
                t3_reg[i] <= mx[i] * px[i % 3];
            end
        end
    end

    // Stage 4: row sums.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n4_reg <= n3_reg;
            for (int i = 0; i < 3; i++)
            begin
                acc4_reg[i] <= t3_reg[3*i] + t3_reg[3*i+1] + t3_reg[3*i+2];
            end
        end
    end

    // Dividend setup: magnitude doubled plus n gives rounding to nearest.
    logic [AccW-1:0] mag [3];
    for (genvar i = 0; i < 3; i++)
    begin : g_mag
        assign mag[i] = acc4_reg[i][AccW-1] ? AccW'(-acc4_reg[i]) : AccW'(acc4_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0] <= {n4_reg, 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= {1'b0, mag[i], 1'b0} + NumW'(n4_reg);
                quo_reg[0][i] <= '0;
                neg_reg[0][i] <= acc4_reg[i][AccW-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage, high bit first.
    for (genvar j = 0; j < DivSteps; j++)
    begin : g_div
        localparam int K = DivSteps - 1 - j;
        logic [NumW-1:0] dsh;
        assign dsh = NumW'(den_reg[j]) << K;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[j+1] <= den_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[j+1][i] <= neg_reg[j][i];
                    if (rem_reg[j][i] >= dsh)
                    begin
                        rem_reg[j+1][i] <= rem_reg[j][i] - dsh;
                        quo_reg[j+1][i] <= quo_reg[j][i] | (QuoW'(1) << K);
                    end
                    else
                    begin
                        rem_reg[j+1][i] <= rem_reg[j][i];
                        quo_reg[j+1][i] <= quo_reg[j][i];
                    end
                end
            end
        end
    end

    // Sign and saturation into the output register.
    comp_t sat_val [3];
    logic  sat_hit [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!neg_reg[DivSteps][i] && (quo_reg[DivSteps][i] > QuoW'(32767)))
            begin
                sat_val[i] = CompMax;
                sat_hit[i] = 1'b1;
            end
            else if (neg_reg[DivSteps][i] && (quo_reg[DivSteps][i] > QuoW'(32768)))
            begin
                sat_val[i] = CompMin;
                sat_hit[i] = 1'b1;
            end
            else
            begin
                sat_val[i] = neg_reg[DivSteps][i] ? comp_t'(-quo_reg[DivSteps][i])
                                                   : comp_t'(quo_reg[DivSteps][i]);
                sat_hit[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= {sat_val[2], sat_val[1], sat_val[0]};
            clip_reg <= sat_hit[0] || sat_hit[1] || sat_hit[2];
        end
    end

endmodule

// ----- rtl/quaternion_rotate_vector.sv -----
// Quaternion rotation of a Q8.8 point, top level.
// Instantiates qrv_front, qrv_queue and qrv_back; depends on qrv_pkg.
//
// Usage:
//   Input channel (s_*): one word holds a raw quaternion (x, y, z, w) and a
//   point (x, y, z) in Q8.8. Only the direction of the quaternion matters;
//   a zero quaternion acts as a half turn about x.
//   Output channel (m_*): one word per input word, in order, holding the
//   rotated point rounded to nearest Q8.8 and saturated, with a clip flag.
// Throughput: one word per cycle when the receiver keeps m_tready high.
// Path: the accepting edge writes the queue; the word then passes through
//   four arithmetic stages, dividend setup, seventeen divider stages (one
//   quotient bit each) and the output register, each stage registered.
// Stalls: when m_tready is low while a result waits, the back end pipeline
//   holds; the queue in front of it keeps accepting until QUEUE_DEPTH words
//   wait, then s_tready drops.
// Reset: rst_n clears the queue and all valid bits; no word is in flight
//   afterwards and the block accepts input in the first cycle.
module quaternion_rotate_vector
    import qrv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // quat_x, quat_y, quat_z, quat_w, point_x, point_y, point_z
    input  logic [ItemW-1:0]   s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [3*CompW-1:0] m_tdata,
    // clipped
    output logic               m_tuser
);

    qctl_t qctl;
    item_t front_item;
    item_t queue_item;
    logic  q_full;
    logic  q_empty;
    logic  back_ready;

    qrv_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .qctl     (qctl),
        .item     (front_item)
    );

    qrv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .qctl    (qctl),
        .wr_item (front_item),
        .full    (q_full),
        .empty   (q_empty),
        .pop     (back_ready),
        .rd_item (queue_item)
    );

    qrv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_ready (back_ready),
        .in_item  (queue_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/qrv_checker.sv -----
// Port-level checker for quaternion_rotate_vector, with its bind statement.
// Depends on qrv_pkg.
module qrv_checker
    import qrv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [3*CompW-1:0] m_tdata,
    input logic               m_tuser
);

    localparam int Capacity = QUEUE_DEPTH + BackStages + 1;

    logic [7:0] pending_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Words accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, in_acc} - {7'd0, out_acc};
        end
    end

    // No result without an earlier input word.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != '0))
        else $error("result delivered with no word in flight");

    // The block never holds more words than its storage allows.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(Capacity))
        else $error("more words in flight than queue and pipeline hold");

    // A clip flag comes only with a coordinate at a rail.
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (m_tdata[15:0] == 16'h7fff) || (m_tdata[15:0] == 16'h8000) ||
            (m_tdata[31:16] == 16'h7fff) || (m_tdata[31:16] == 16'h8000) ||
            (m_tdata[47:32] == 16'h7fff) || (m_tdata[47:32] == 16'h8000))
        else $error("clip flag set without a saturated coordinate");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind quaternion_rotate_vector qrv_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_qrv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/quaternion_rotate_vector_test.sv -----
// Self-checking bench for quaternion_rotate_vector: random and directed
// quaternion/point words, exact integer rotation prediction, in-order check.
// Depends on qrv_pkg and the quaternion_rotate_vector RTL.
module quaternion_rotate_vector_test;
    import qrv_pkg::*;

    typedef struct packed {
        logic       clip;
        logic [15:0] rz;
        logic [15:0] ry;
        logic [15:0] rx;
    } rot_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [ItemW-1:0]   s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [3*CompW-1:0] m_tdata;
    logic               m_tuser;
    logic               s_tready_seen;

    item_t pending_words[$];
    rot_t  expected_points[$];
    int    errors;
    int    cycle_count;
    int    burst_left;
    int    gap_left;
    bit    hold_off;
    bit    stim_done;

    quaternion_rotate_vector uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Rounded quotient, ties away from zero.
    function automatic longint round_div(longint a, longint n);
        longint mag;
        longint q;
        mag = (a < 0) ? -a : a;
        q = (mag * 2 + n) / (n * 2);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic [15:0] clamp16(longint v, ref logic clip);
        if (v > 32767)
        begin
            clip = 1'b1;
            v = 32767;
        end
        if (v < -32768)
        begin
            clip = 1'b1;
            v = -32768;
        end
        return v[15:0];
    endfunction

    // Rotate by n*R exactly, then divide by the norm once.
    function automatic rot_t rotate_point(item_t it);
        longint x, y, z, w, n, acc;
        longint p[3];
        longint m[3][3];
        logic   clip;
        logic [15:0] r[3];
        x = longint'(it.qx); y = longint'(it.qy); z = longint'(it.qz); w = longint'(it.qw);
        p[0] = longint'(it.px); p[1] = longint'(it.py); p[2] = longint'(it.pz);
        clip = 1'b0;
        // A zero quaternion stands for a half turn about x.
        if (x == 0 && y == 0 && z == 0 && w == 0)
            x = 1;
        n = x*x + y*y + z*z + w*w;
        m[0][0] = w*w + x*x - y*y - z*z;
        m[0][1] = 2 * (x*y - w*z);
        m[0][2] = 2 * (x*z + w*y);
        m[1][0] = 2 * (x*y + w*z);
        m[1][1] = w*w - x*x + y*y - z*z;
        m[1][2] = 2 * (y*z - w*x);
        m[2][0] = 2 * (x*z - w*y);
        m[2][1] = 2 * (y*z + w*x);
        m[2][2] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[i][0]*p[0] + m[i][1]*p[1] + m[i][2]*p[2];
            r[i] = clamp16(round_div(acc, n), clip);
        end
        return '{clip: clip, rz: r[2], ry: r[1], rx: r[0]};
    endfunction

    function automatic comp_t pick_comp();
        case ($urandom_range(0, 7))
            0: return CompMax;
            1: return CompMin;
            2: return comp_t'(int'($urandom_range(0, 6)) - 3);
            3: return comp_t'(int'($urandom_range(0, 1023)) - 512);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic item_t make_word(comp_t qx, comp_t qy, comp_t qz, comp_t qw,
                                        comp_t px, comp_t py, comp_t pz);
        return '{pz: pz, py: py, px: px, qw: qw, qz: qz, qy: qy, qx: qx};
    endfunction

    // Stimulus: directed corners first, then random words.
    initial
    begin
        item_t it;
        errors = 0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        // Zero quaternion, including the negation overflow.
        pending_words.push_back(make_word(0, 0, 0, 0, 16'sh0100, 16'sh0200, 16'sh0300));
        pending_words.push_back(make_word(0, 0, 0, 0, CompMin, CompMin, CompMin));
        pending_words.push_back(make_word(0, 0, 0, 0, CompMax, CompMax, CompMax));
        // Identity and quarter and half turns.
        pending_words.push_back(make_word(0, 0, 0, 1, CompMax, CompMin, 16'sh0001));
        pending_words.push_back(make_word(0, 0, 0, CompMin, 16'sh1234, -16'sh0567, 0));
        pending_words.push_back(make_word(0, 0, 1, 1, 16'sh0100, 0, 0));
        pending_words.push_back(make_word(0, 1, 0, 1, 0, 0, 16'sh0100));
        pending_words.push_back(make_word(1, 0, 0, 1, 0, 16'sh0100, 0));
        pending_words.push_back(make_word(0, CompMax, 0, 0, CompMax, 0, CompMin));
        // Diagonal turns that push extreme points past the range.
        pending_words.push_back(make_word(0, 0, 1, 2, CompMax, CompMax, 0));
        pending_words.push_back(make_word(1, 1, 1, 1, CompMin, CompMin, CompMin));
        pending_words.push_back(make_word(CompMax, CompMax, CompMax, CompMax,
                                          CompMax, CompMax, CompMax));
        pending_words.push_back(make_word(CompMin, CompMin, CompMin, CompMin,
                                          CompMin, CompMax, CompMin));
        pending_words.push_back(make_word(CompMin, CompMax, CompMin, CompMax,
                                          CompMax, CompMin, CompMax));
        // Rounding: an odd point turned about z with norm 25, and a half turn about x.
        pending_words.push_back(make_word(0, 0, 3, 4, 16'sh0001, 16'sh0003, -16'sh0001));
        pending_words.push_back(make_word(-1, 0, 0, 0, -16'sh0001, 16'sh0001, 16'sh0001));
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int k = 0; k < 1300; k++)
        begin
            it = make_word(pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                           pick_comp(), pick_comp(), pick_comp());
            if ($urandom_range(0, 15) == 0)
            begin
                it.qx = 0; it.qy = 0; it.qz = 0; it.qw = 0;
            end
            pending_words.push_back(it);
            // Midway, let the pipeline drain completely before going on.
            if (k == 650)
            begin
                wait (pending_words.size() == 0);
                hold_off = 1'b1;
                wait (expected_points.size() == 0);
                @(negedge clk);
                hold_off = 1'b0;
            end
        end
        wait (pending_words.size() == 0);
        stim_done = 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready_seen)
            begin
                // Word was taken at the last rising edge.
            end
            if (!s_tvalid || s_tready_seen)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0 && !hold_off)
                begin
                    s_tdata <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Acceptance of the driven word, seen at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tready_seen <= 1'b0;
        else
        begin
            s_tready_seen <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_points.push_back(rotate_point(item_t'(s_tdata)));
        end
    end

    // Receiver stalls in phases: quiet stretches and noisy ones.
    int stall_phase;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                m_tready <= 1'b1;
            else if (stall_phase < 200)
                m_tready <= ($urandom_range(0, 3) != 0);
            else
                m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Result check against the oldest prediction.
    always @(posedge clk)
    begin
        rot_t got;
        rot_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{clip: m_tuser, rz: m_tdata[47:32], ry: m_tdata[31:16],
                    rx: m_tdata[15:0]};
            if (expected_points.size() == 0)
            begin
                $error("unexpected output word %h", got);
                errors++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (got.rx !== want.rx)
                begin
                    $error("rotated_x expected %0d got %0d", $signed(want.rx), $signed(got.rx));
                    errors++;
                end
                if (got.ry !== want.ry)
                begin
                    $error("rotated_y expected %0d got %0d", $signed(want.ry), $signed(got.ry));
                    errors++;
                end
                if (got.rz !== want.rz)
                begin
                    $error("rotated_z expected %0d got %0d", $signed(want.rz), $signed(got.rz));
                    errors++;
                end
                if (got.clip !== want.clip)
                begin
                    $error("clipped expected %0b got %0b", want.clip, got.clip);
                    errors++;
                end
            end
        end
    end

    // End of run and watchdog.
    initial
    begin
        cycle_count = 0;
        fork
            begin
                wait (stim_done && !s_tvalid && expected_points.size() == 0);
                repeat (40) @(posedge clk);
                if (errors == 0 && expected_points.size() == 0)
                    $display("RESULT: OK");
                else
                    $display("RESULT: ERROR");
                $finish;
            end
            begin
                while (cycle_count < 200000)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                $display("RESULT: ERROR");
                $finish;
            end
        join
    end

endmodule
